[rtl/top_k_sorted_insert_table_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the top-k sorted insert table
// Concurrent checks that compile out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef TOP_K_SORTED_INSERT_TABLE_ASSERT_SVH
`define TOP_K_SORTED_INSERT_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Implication or plain property, clocked, off during reset.
`define TKSI_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
    else $error("tksi assertion failed");

// Same check but also live while reset is held.
`define TKSI_ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) (prop)) \
    else $error("tksi assertion failed");

`else

`define TKSI_ASSERT(lbl, ck, rn, prop)
`define TKSI_ASSERT_ALWAYS(lbl, ck, prop)

`endif

`endif

[rtl/tksi_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tksi_pkg
// Shared types and constants for the top-k sorted insert table.
// ---------------------------------------------------------------------------
package tksi_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 4;
  localparam int OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SUBMIT = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // Controller -> datapath strobes.
  typedef struct packed {
    logic latch;        // capture input beat, reset scan state
    logic clear;        // empty the table
    logic rd_scan;      // read entry at idx
    logic idx_inc;      // advance scan index
    logic set_pos_idx;  // insert/dup position = idx
    logic set_pos_cnt;  // position = count (not found)
    logic shift_init;   // idx = last slot to fill when shifting
    logic rd_prev;      // read entry at idx-1
    logic wr_shift;     // entry[idx] = read data, idx--
    logic ins;          // entry[pos] = value, bump count
    logic rd_rank;      // read entry at requested rank
    logic load_out;     // fill output register
  } cmd_t;

  // Datapath -> controller flags.
  typedef struct packed {
    logic empty;        // no entries held
    logic ge;           // read data >= submitted value
    logic idx_last;     // idx is last held entry
    logic dup;          // value already held
    logic pos_ok;       // position inside the table
    logic shift_more;   // idx above pos, shifting not done
    logic out_busy;     // output register full and not taken
  } sts_t;

endpackage

[rtl/tksi_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tksi_ctrl
// Sequencer: scan for position, shift tail down, insert, report; read and clear.
// ---------------------------------------------------------------------------
module tksi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tksi_pkg::op_t   in_opcode,
  input  tksi_pkg::sts_t  sts,
  output tksi_pkg::cmd_t  cmd
);
  import tksi_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_SCAN_RD = 9'b000000010,
    S_SCAN_CM = 9'b000000100,
    S_SH_CHK  = 9'b000001000,
    S_SH_TEST = 9'b000010000,
    S_SH_WR   = 9'b000100000,
    S_INSERT  = 9'b001000000,
    S_RD      = 9'b010000000,
    S_FINISH  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (in_opcode)
            OP_SUBMIT: state_nxt = S_SCAN_RD;
            OP_CLEAR: begin
              cmd.clear = 1'b1;
              state_nxt = S_FINISH;
            end
            OP_READ:   state_nxt = S_RD;
            OP_NOP:    state_nxt = S_FINISH;
            default:   state_nxt = S_FINISH;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (sts.empty) begin
          cmd.set_pos_cnt = 1'b1;
          state_nxt       = S_SH_CHK;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_SCAN_CM;
        end
      end
      S_SCAN_CM: begin
        priority if (sts.ge) begin
          cmd.set_pos_idx = 1'b1;
          state_nxt       = S_SH_CHK;
        end else if (sts.idx_last) begin
          cmd.set_pos_cnt = 1'b1;
          state_nxt       = S_SH_CHK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SH_CHK: begin
        if (sts.dup || !sts.pos_ok) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SH_TEST;
        end
      end
      S_SH_TEST: begin
        if (sts.shift_more) begin
          cmd.rd_prev = 1'b1;
          state_nxt   = S_SH_WR;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        state_nxt    = S_SH_TEST;
      end
      S_INSERT: begin
        cmd.ins   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_RD: begin
        cmd.rd_rank = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/tksi_dp.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tksi_dp
// Entry memory, count, scan index, position and output register.
// ---------------------------------------------------------------------------
`include "top_k_sorted_insert_table_assert.svh"

module tksi_dp #(
  parameter int TABLE_DEPTH = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tksi_pkg::cmd_t               cmd,
  output tksi_pkg::sts_t               sts,
  input  tksi_pkg::op_t                in_opcode,
  input  logic [tksi_pkg::VALUE_W-1:0] in_time_value,
  input  logic [tksi_pkg::RANK_W-1:0]  in_read_rank,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tksi_pkg::RANK_W-1:0]  out_rank_of_value,
  output logic                         out_was_stored,
  output logic [tksi_pkg::VALUE_W-1:0] out_entry_value,
  output logic [tksi_pkg::RANK_W-1:0]  out_entry_count
);
  import tksi_pkg::*;

  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(TABLE_DEPTH - 1);

  logic [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  op_t                op_r;
  logic [VALUE_W-1:0] val_r;
  logic [RANK_W-1:0]  rrank_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic               dup_r, dup_nxt;
  logic               stored_r, stored_nxt;

  logic               out_valid_r;
  logic [RANK_W-1:0]  out_rank_r;
  logic               out_stored_r;
  logic [VALUE_W-1:0] out_entry_r;
  logic [RANK_W-1:0]  out_count_r;

  logic [AW-1:0]      rd_addr, wr_addr;
  logic [VALUE_W-1:0] wr_data;
  logic               rd_en, wr_en;

  logic [CNT_W-1:0]   idx_m1;
  logic [CNT_W:0]     idx_p1;
  logic [RANK_W-1:0]  rrank_m1;
  logic [AW+RANK_W-1:0] rrank_m1_ext;
  logic               rank_ok;
  logic [CNT_W:0]     rank_w;
  logic [CNT_W+RANK_W:0] rank_ext;
  logic [CNT_W+RANK_W-1:0] count_ext;

  assign idx_m1       = idx_r - 1'b1;
  assign idx_p1       = {1'b0, idx_r} + 1'b1;
  assign rrank_m1     = rrank_r - 1'b1;
  assign rrank_m1_ext = {{AW{1'b0}}, rrank_m1};
  assign rank_ok      = (rrank_r != '0) &&
                        ({{CNT_W{1'b0}}, rrank_r} <= {{RANK_W{1'b0}}, count_r});
  // pos+1 covers all submit cases: hit, insert, and dropped (pos = count)
  assign rank_w       = {1'b0, pos_r} + 1'b1;
  assign rank_ext     = {{RANK_W{1'b0}}, rank_w};
  assign count_ext    = {{RANK_W{1'b0}}, count_r};

  // status
  assign sts.empty      = (count_r == '0);
  assign sts.ge         = (rd_data_r >= val_r);
  assign sts.idx_last   = (idx_p1 == {1'b0, count_r});
  assign sts.dup        = dup_r;
  assign sts.pos_ok     = (pos_r < DEPTH_C);
  assign sts.shift_more = (idx_r > pos_r);
  assign sts.out_busy   = out_valid_r && !out_ready;

  // memory ports
  always_comb begin
    rd_en   = cmd.rd_scan || cmd.rd_prev || cmd.rd_rank;
    rd_addr = idx_r[AW-1:0];
    if (cmd.rd_prev) begin
      rd_addr = idx_m1[AW-1:0];
    end else if (cmd.rd_rank) begin
      rd_addr = rrank_m1_ext[AW-1:0];
    end
    wr_en   = cmd.wr_shift || cmd.ins;
    wr_addr = cmd.ins ? pos_r[AW-1:0] : idx_r[AW-1:0];
    wr_data = cmd.ins ? val_r : rd_data_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // control registers
  always_comb begin
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    pos_nxt    = pos_r;
    dup_nxt    = dup_r;
    stored_nxt = stored_r;
    if (cmd.latch) begin
      idx_nxt    = '0;
      dup_nxt    = 1'b0;
      stored_nxt = 1'b0;
    end
    if (cmd.clear) begin
      count_nxt = '0;
    end
    if (cmd.idx_inc) begin
      idx_nxt = idx_p1[CNT_W-1:0];
    end
    if (cmd.set_pos_idx) begin
      pos_nxt = idx_r;
      dup_nxt = (rd_data_r == val_r);
    end
    if (cmd.set_pos_cnt) begin
      pos_nxt = count_r;
      dup_nxt = 1'b0;
    end
    if (cmd.shift_init) begin
      idx_nxt = (count_r < DEPTH_C) ? count_r : LAST_C;
    end
    if (cmd.wr_shift) begin
      idx_nxt = idx_m1;
    end
    if (cmd.ins) begin
      stored_nxt = 1'b1;
      if (count_r < DEPTH_C) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      pos_r    <= '0;
      dup_r    <= 1'b0;
      stored_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      dup_r    <= dup_nxt;
      stored_r <= stored_nxt;
    end
  end

  // captured input beat
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r    <= in_opcode;
      val_r   <= in_time_value;
      rrank_r <= in_read_rank;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rank_r   <= (op_r == OP_SUBMIT) ? rank_ext[RANK_W-1:0] : '0;
      out_stored_r <= (op_r == OP_SUBMIT) && stored_r;
      out_entry_r  <= ((op_r == OP_READ) && rank_ok) ? rd_data_r : '0;
      out_count_r  <= count_ext[RANK_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rank_of_value = out_rank_r;
  assign out_was_stored    = out_stored_r;
  assign out_entry_value   = out_entry_r;
  assign out_entry_count   = out_count_r;

  `TKSI_ASSERT_ALWAYS(a_count_bound, clk, !rst_n || (count_r <= DEPTH_C))
  `TKSI_ASSERT(a_ins_in_range, clk, rst_n, cmd.ins |-> (pos_r < DEPTH_C) && !dup_r)
  `TKSI_ASSERT(a_ins_grows, clk, rst_n,
    (cmd.ins && (count_r < DEPTH_C)) |=> (count_r == $past(count_r) + 1'b1))
  `TKSI_ASSERT(a_no_overwrite, clk, rst_n, cmd.load_out |-> !(out_valid_r && !out_ready))

endmodule

[rtl/top_k_sorted_insert_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_k_sorted_insert_table
// Ordered table of the TABLE_DEPTH smallest distinct 32-bit time values.
// ---------------------------------------------------------------------------
// Keeps up to TABLE_DEPTH distinct unsigned values in ascending order in a
// single-port-write / single-port-read memory. Each input beat gives exactly
// one result beat. Submit: the value is searched for by a linear scan, each
// entry read from memory and then compared, stopping at the first entry not
// smaller than it; a hit leaves the table alone, a value past the end of a
// full table is dropped, otherwise the tail is moved down one slot at a time
// (each moved entry read, then written) and the value written in its place.
// On every insert into a full table, scan and shift together walk the whole
// table. The result is loaded in the cycle before in_ready returns. The
// memory port does one access per cycle. Only one item is in the sequencer
// at a time: in_ready is high while the sequencer is idle, and the finished
// result sits in an output register, so the next beat is taken while the
// previous result waits for out_ready; that next result then holds the
// sequencer until the register frees up. The table needs no clearing pass
// after reset; entries past the held count are never returned. rank_of_value
// and entry_count are 4 bits wide and wrap for depths above 14.
// ---------------------------------------------------------------------------
module top_k_sorted_insert_table #(
  parameter int TABLE_DEPTH = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tksi_pkg::OP_W-1:0]    in_opcode,
  input  logic [tksi_pkg::VALUE_W-1:0] in_time_value,
  input  logic [tksi_pkg::RANK_W-1:0]  in_read_rank,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tksi_pkg::RANK_W-1:0]  out_rank_of_value,
  output logic                         out_was_stored,
  output logic [tksi_pkg::VALUE_W-1:0] out_entry_value,
  output logic [tksi_pkg::RANK_W-1:0]  out_entry_count
);
  import tksi_pkg::*;

  cmd_t cmd;
  sts_t sts;
  op_t  in_op;

  // raw opcode bits map one to one onto the enum
  assign in_op = op_t'(in_opcode);

  tksi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_op),
    .sts       (sts),
    .cmd       (cmd)
  );

  tksi_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_opcode         (in_op),
    .in_time_value     (in_time_value),
    .in_read_rank      (in_read_rank),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rank_of_value (out_rank_of_value),
    .out_was_stored    (out_was_stored),
    .out_entry_value   (out_entry_value),
    .out_entry_count   (out_entry_count)
  );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - regression bench for top_k_sorted_insert_table
// Runs a directed table, then about 1200 random beats through the valid/ready
// input channel. Every accepted beat is run through a local copy of the
// sorted table, and each result beat is compared field by field with the
// oldest pending prediction. The sender works in bursts and the receiver
// stalls on its own pattern, with one long hold-off that backs up the block.
// ---------------------------------------------------------------------------
module tb_top;
  import tksi_pkg::*;

  localparam int TBL_DEPTH    = 10;
  localparam int RAND_BEATS   = 1200;
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 9;
  // Drain well past the longest submit.
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int HOLD_AT      = 400;   // beats accepted before the long hold-off
  localparam int HOLD_CYCLES  = 300;
  localparam int REPORT_MAX   = 10;

  // One result beat, as the block presents it.
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic               stored;
    logic [VALUE_W-1:0] entry;
    logic [RANK_W-1:0]  count;
  } table_result_t;

  // One directed stimulus row. typed=1 means 'want' is checked as written;
  // otherwise the predictor supplies the expectation.
  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
    logic [RANK_W-1:0]  rank;
    logic               typed;
    table_result_t      want;
  } dir_row_t;

  localparam int DIR_N = 26;

  logic clk;
  logic rst_n;

  logic               in_valid;
  logic               in_ready;
  logic [OP_W-1:0]    in_opcode;
  logic [VALUE_W-1:0] in_time_value;
  logic [RANK_W-1:0]  in_read_rank;

  logic               out_valid;
  logic               out_ready;
  logic [RANK_W-1:0]  out_rank_of_value;
  logic               out_was_stored;
  logic [VALUE_W-1:0] out_entry_value;
  logic [RANK_W-1:0]  out_entry_count;

  // Local copy of the table. Entries at or past sorted_cnt are never read.
  logic [VALUE_W-1:0] sorted_vals [TBL_DEPTH];
  int unsigned        sorted_cnt;

  table_result_t pending_results[$];

  int unsigned beats_in;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned op_hits [4];
  int unsigned full_submits;   // submits that met a full table
  int unsigned dup_submits;
  int unsigned burst_left;
  bit          hold_done;

  // Directed rows: extremes of the value, every opcode, duplicates, drop
  // past a full table, reads at rank zero and past the count, clears.
  dir_row_t dir_rows [DIR_N] = '{
    // fresh out of reset: nothing held
    '{OP_READ,   32'd0,          4'd1,  1'b1, '{4'd0,  1'b0, 32'd0,          4'd0}},
    '{OP_NOP,    32'hFFFF_FFFF,  4'd15, 1'b1, '{4'd0,  1'b0, 32'd0,          4'd0}},
    '{OP_SUBMIT, 32'hFFFF_FFFF,  4'd0,  1'b1, '{4'd1,  1'b1, 32'd0,          4'd1}},
    '{OP_SUBMIT, 32'd0,          4'd15, 1'b1, '{4'd1,  1'b1, 32'd0,          4'd2}},
    // duplicate of the head leaves the table alone
    '{OP_SUBMIT, 32'd0,          4'd0,  1'b1, '{4'd1,  1'b0, 32'd0,          4'd2}},
    '{OP_READ,   32'hFFFF_FFFF,  4'd0,  1'b1, '{4'd0,  1'b0, 32'd0,          4'd2}},
    '{OP_READ,   32'd0,          4'd15, 1'b1, '{4'd0,  1'b0, 32'd0,          4'd2}},
    '{OP_READ,   32'd0,          4'd2,  1'b1, '{4'd0,  1'b0, 32'hFFFF_FFFF,  4'd2}},
    '{OP_CLEAR,  32'hFFFF_FFFF,  4'd15, 1'b1, '{4'd0,  1'b0, 32'd0,          4'd0}},
    // fill to depth in scrambled order
    '{OP_SUBMIT, 32'd500,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd100,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd900,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd300,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd700,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd200,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd1000,       4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd400,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd800,        4'd0,  1'b0, '0},
    '{OP_SUBMIT, 32'd600,        4'd0,  1'b0, '0},
    // larger than everything with the table full: dropped
    '{OP_SUBMIT, 32'hFFFF_FFFF,  4'd0,  1'b1, '{4'd11, 1'b0, 32'd0,          4'd10}},
    '{OP_READ,   32'd0,          4'd10, 1'b0, '0},
    // new head on a full table pushes the tail out
    '{OP_SUBMIT, 32'd50,         4'd0,  1'b0, '0},
    '{OP_READ,   32'd0,          4'd10, 1'b0, '0},
    '{OP_SUBMIT, 32'd900,        4'd0,  1'b0, '0},
    '{OP_READ,   32'd0,          4'd11, 1'b1, '{4'd0,  1'b0, 32'd0,          4'd10}},
    '{OP_CLEAR,  32'd0,          4'd0,  1'b1, '{4'd0,  1'b0, 32'd0,          4'd0}}
  };

  top_k_sorted_insert_table #(
    .TABLE_DEPTH (TBL_DEPTH)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_time_value     (in_time_value),
    .in_read_rank      (in_read_rank),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rank_of_value (out_rank_of_value),
    .out_was_stored    (out_was_stored),
    .out_entry_value   (out_entry_value),
    .out_entry_count   (out_entry_count)
  );

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // Applies one accepted beat to the local table and returns its result.
  function automatic table_result_t sorted_table_apply(input op_t op,
                                                       input logic [VALUE_W-1:0] val,
                                                       input logic [RANK_W-1:0] rk);
    table_result_t res;
    bit            hit;
    bit            found;
    int unsigned   pos;
    int unsigned   last;
    res = '0;
    op_hits[op]++;
    case (op)
      OP_SUBMIT: begin
        hit = 1'b0;
        pos = sorted_cnt;
        for (int i = 0; i < sorted_cnt; i++) begin
          if (!hit && sorted_vals[i] == val) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (sorted_cnt == TBL_DEPTH) full_submits++;
        if (hit) begin
          dup_submits++;
          res.rank = RANK_W'(pos + 1);
        end else begin
          // insertion point: first entry not smaller than the value
          found = 1'b0;
          pos = sorted_cnt;
          for (int i = 0; i < sorted_cnt; i++) begin
            if (!found && sorted_vals[i] >= val) begin
              found = 1'b1;
              pos = i;
            end
          end
          if (pos < TBL_DEPTH) begin
            last = (sorted_cnt < TBL_DEPTH) ? sorted_cnt : TBL_DEPTH - 1;
            for (int i = last; i > pos; i--) sorted_vals[i] = sorted_vals[i-1];
            sorted_vals[pos] = val;
            if (sorted_cnt < TBL_DEPTH) sorted_cnt++;
            res.stored = 1'b1;
            res.rank   = RANK_W'(pos + 1);
          end else begin
            res.rank = RANK_W'(sorted_cnt + 1);
          end
        end
      end
      OP_CLEAR: sorted_cnt = 0;
      OP_READ: begin
        if (rk >= 1 && rk <= sorted_cnt) res.entry = sorted_vals[rk-1];
      end
      default: ;
    endcase
    res.count = RANK_W'(sorted_cnt);
    return res;
  endfunction

  // Offers one beat, holds it until taken, then records its prediction.
  // Gaps come between bursts of random length; some bursts are long.
  task automatic offer_beat(input op_t op, input logic [VALUE_W-1:0] val,
                            input logic [RANK_W-1:0] rk, input logic typed,
                            input table_result_t want);
    table_result_t res;
    int unsigned   gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_time_value <= val;
    in_read_rank  <= rk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = sorted_table_apply(op, val, rk);
    if (typed) res = want;
    pending_results.push_back(res);
    beats_in++;
  endtask

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycles, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: changes stall pattern every so often, plus one long hold-off
  // once traffic is flowing so the block backs up and drops in_ready.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    int unsigned hold_cnt;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && beats_in >= HOLD_AT) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        phase++;
        case (mode)
          0:       out_ready <= 1'b1;                          // no stalls
          1:       out_ready <= 1'($urandom_range(0, 1));      // coin flip
          2:       out_ready <= (phase % 4 == 0);              // one in four
          default: out_ready <= ($urandom_range(0, 99) < 85);  // light stalls
        endcase
      end
    end
  end

  // Result checker: every taken result beat pairs with the oldest prediction.
  always @(posedge clk) begin
    table_result_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected result beat: rank %0d stored %0d entry %h count %0d",
                   out_rank_of_value, out_was_stored, out_entry_value, out_entry_count);
        mismatches <= mismatches + 1;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_rank_of_value !== exp_res.rank || out_was_stored !== exp_res.stored ||
            out_entry_value !== exp_res.entry || out_entry_count !== exp_res.count) begin
          if (mismatches < REPORT_MAX) begin
            $display("mismatch at result %0d: exp rank %0d stored %0d entry %h count %0d",
                     results_seen, exp_res.rank, exp_res.stored, exp_res.entry,
                     exp_res.count);
            $display("                        got rank %0d stored %0d entry %h count %0d",
                     out_rank_of_value, out_was_stored, out_entry_value,
                     out_entry_count);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random beats, drain, verdict.
  initial begin
    op_t                op;
    logic [VALUE_W-1:0] v;
    logic [RANK_W-1:0]  rk;
    int unsigned        r;
    int unsigned        vmode;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = '0;
    in_time_value = '0;
    in_read_rank  = '0;
    sorted_cnt    = 0;
    for (int i = 0; i < TBL_DEPTH; i++) sorted_vals[i] = '0;
    beats_in      = 0;
    results_seen  = 0;
    mismatches    = 0;
    cycles        = 0;
    full_submits  = 0;
    dup_submits   = 0;
    burst_left    = 0;
    hold_done     = 1'b0;
    for (int i = 0; i < 4; i++) op_hits[i] = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      offer_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].rank,
                 dir_rows[i].typed, dir_rows[i].want);

    // Random part: submit-heavy so the table fills, overflows and sees
    // duplicates; clears are rare enough that full tables are common.
    for (int n = 0; n < RAND_BEATS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 62)      op = OP_SUBMIT;
      else if (r < 88) op = OP_READ;
      else if (r < 92) op = OP_CLEAR;
      else             op = OP_NOP;

      vmode = $urandom_range(0, 9);
      if (vmode < 4)       v = $urandom_range(0, 40);
      else if (vmode < 6)  v = $urandom;
      else if (vmode == 6) v = 32'hFFFF_FFFF - $urandom_range(0, 20);
      else if (vmode == 7) v = $urandom_range(0, 3);
      else if (sorted_cnt > 0) v = sorted_vals[$urandom_range(0, sorted_cnt - 1)];
      else                 v = $urandom;

      rk = ($urandom_range(0, 3) == 0) ? RANK_W'($urandom_range(0, 15))
                                       : RANK_W'($urandom_range(1, TBL_DEPTH + 1));
      offer_beat(op, v, rk, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) mismatches = mismatches + pending_results.size();

    $display("covered %0d beats: %0d submit, %0d read, %0d clear, %0d nop",
             beats_in, op_hits[OP_SUBMIT], op_hits[OP_READ], op_hits[OP_CLEAR],
             op_hits[OP_NOP]);
    $display("%0d results checked, submits on a full table %0d, duplicate submits %0d",
             results_seen, full_submits, dup_submits);
    $display("mismatches %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
